>>> rtl/sct_pkg.sv
package sct_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int KEY_W         = 31;
   localparam int COUNT_W       = 32;
   localparam int USED_W        = $clog2(TABLE_ENTRIES + 1);
   localparam int ENTRIES_OUT_W = 7;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // what the travelling token still has to do
   typedef enum logic [1:0] {
      TOK_SEARCH,
      TOK_COMPACT,
      TOK_CLEAR,
      TOK_DONE
   } tok_mode_type;

   typedef struct packed {
      logic                 valid;
      tok_mode_type         mode;
      logic                 is_add;
      logic                 neg;
      logic [KEY_W-1:0]     key;
      logic [COUNT_W-1:0]   amount;
      logic [COUNT_W-1:0]   held;
      logic                 alloc;
      logic                 freed;
   } token_type;

   // entry moved one cell toward the head during compaction
   typedef struct packed {
      logic                 load;
      logic [KEY_W-1:0]     key;
      logic [COUNT_W-1:0]   count;
   } shift_type;

endpackage

>>> rtl/signed_count_table.sv
// Channel  | Direction | Ports                                   | Transfer when
// ---------+-----------+-----------------------------------------+----------------------
// request  | in        | req_operation, req_key, req_amount      | req_valid & req_ready
// response | out       | rsp_found_count, rsp_entries_used,      | rsp_valid & rsp_ready
//          |           | rsp_table_empty, rsp_table_full_error   |
//
// One item at a time: a token walks the row of TABLE_ENTRIES cells, one cell
// per cycle, then passes through the finish register into the response
// register; the next request is taken once the result has moved into the
// response register.
// Reset clears every cell's valid bit, the token stages and the use count.
// A stalled response holds in a finish register; the row is never stalled.
module signed_count_table
   import sct_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_operation,
   input  logic signed [31:0]              req_key,
   input  logic signed [31:0]              req_amount,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [31:0]              rsp_found_count,
   output logic [ENTRIES_OUT_W-1:0]        rsp_entries_used,
   output logic                            rsp_table_empty,
   output logic                            rsp_table_full_error
);

   token_type tok_link [0:TABLE_ENTRIES];
   shift_type shift_link [0:TABLE_ENTRIES];

   logic               busy_ff, busy_in;
   logic [USED_W-1:0]  used_ff, used_in;
   logic               req_xfer;
   logic [31:0]        key_mag;
   token_type          tok_head;
   token_type          tok_tail;

   // finish stage, between the row and the response register
   logic               fin_valid_ff, fin_valid_in;
   logic [COUNT_W-1:0] fin_count_ff, fin_count_in;
   logic [USED_W-1:0]  fin_used_ff;
   logic               fin_err_ff, fin_err_in;
   logic               fin_move;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [USED_W-1:0]  rsp_used_ff;
   logic               rsp_err_ff;

   assign req_ready = !busy_ff;
   assign req_xfer  = req_valid && req_ready;

   // fold negative keys to magnitude, count negated; -2^31 lands on key 0
   assign key_mag = req_key[31] ? (32'd0 - req_key) : req_key;

   always_comb begin
      tok_head        = '0;
      tok_head.valid  = req_xfer;
      tok_head.neg    = req_key[31];
      tok_head.key    = key_mag[KEY_W-1:0];
      tok_head.amount = req_key[31] ? (32'd0 - req_amount) : req_amount;
      tok_head.is_add = (op_type'(req_operation) == OP_ADD);
      case (op_type'(req_operation))
         OP_ADD, OP_LOOKUP: tok_head.mode = TOK_SEARCH;
         OP_CLEAR:          tok_head.mode = TOK_CLEAR;
         default:           tok_head.mode = TOK_DONE;
      endcase
   end

   assign tok_link[0]               = tok_head;
   assign shift_link[TABLE_ENTRIES] = '0;

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      sct_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .tok_in    (tok_link[i]),
         .tok_out   (tok_link[i+1]),
         .shift_in  (shift_link[i+1]),
         .shift_out (shift_link[i])
      );
   end

   assign tok_tail = tok_link[TABLE_ENTRIES];
   assign fin_move = fin_valid_ff && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      used_in      = used_ff;
      fin_valid_in = fin_valid_ff;
      fin_count_in = fin_count_ff;
      fin_err_in   = fin_err_ff;
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;

      if (req_xfer) begin
         busy_in = 1'b1;
      end

      if (tok_tail.valid) begin
         // still searching at the end: every cell is in use and none matched
         fin_err_in   = (tok_tail.mode == TOK_SEARCH) && tok_tail.is_add &&
                        (tok_tail.amount != '0);
         fin_count_in = tok_tail.neg ? (32'd0 - tok_tail.held) : tok_tail.held;
         fin_valid_in = 1'b1;
         if (tok_tail.mode == TOK_CLEAR) begin
            used_in = '0;
         end else begin
            used_in = used_ff + USED_W'(tok_tail.alloc) - USED_W'(tok_tail.freed);
         end
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (fin_move) begin
         rsp_valid_in = 1'b1;
         fin_valid_in = 1'b0;
         busy_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         used_ff      <= '0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         used_ff      <= used_in;
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fin_count_ff <= fin_count_in;
      fin_err_ff   <= fin_err_in;
      if (tok_tail.valid) begin
         fin_used_ff <= used_in;
      end
      if (fin_move) begin
         rsp_count_ff <= fin_count_ff;
         rsp_used_ff  <= fin_used_ff;
         rsp_err_ff   <= fin_err_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_found_count      = rsp_count_ff;
   assign rsp_entries_used     = ENTRIES_OUT_W'(rsp_used_ff);
   assign rsp_table_empty      = (rsp_used_ff == '0);
   assign rsp_table_full_error = rsp_err_ff;

endmodule

>>> rtl/sct_cell.sv
module sct_cell
   import sct_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  token_type tok_in,
   output token_type tok_out,
   input  shift_type shift_in,
   output shift_type shift_out
);

   logic               valid_ff, valid_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   token_type          tok_ff, tok_in_next;
   logic [COUNT_W-1:0] sum;

   assign sum     = count_ff + tok_in.amount;
   assign tok_out = tok_ff;

   always_comb begin
      valid_in    = valid_ff;
      key_in      = key_ff;
      count_in    = count_ff;
      tok_in_next = tok_in;
      shift_out   = '0;

      // right neighbor hands its entry down; never coincides with a token here
      if (shift_in.load) begin
         valid_in = 1'b1;
         key_in   = shift_in.key;
         count_in = shift_in.count;
      end

      if (tok_in.valid) begin
         case (tok_in.mode)
            TOK_CLEAR: begin
               valid_in = 1'b0;
            end
            TOK_SEARCH: begin
               if (valid_ff && key_ff == tok_in.key) begin
                  tok_in_next.mode = TOK_DONE;
                  if (tok_in.is_add) begin
                     if (sum == '0) begin
                        valid_in          = 1'b0;
                        tok_in_next.freed = 1'b1;
                        tok_in_next.mode  = TOK_COMPACT;
                     end else begin
                        count_in         = sum;
                        tok_in_next.held = sum;
                     end
                  end else begin
                     tok_in_next.held = count_ff;
                  end
               end else if (!valid_ff) begin
                  // entries are packed at the head: first free cell ends the search
                  tok_in_next.mode = TOK_DONE;
                  if (tok_in.is_add && tok_in.amount != '0) begin
                     valid_in          = 1'b1;
                     key_in            = tok_in.key;
                     count_in          = tok_in.amount;
                     tok_in_next.held  = tok_in.amount;
                     tok_in_next.alloc = 1'b1;
                  end
               end
            end
            TOK_COMPACT: begin
               if (valid_ff) begin
                  shift_out.load  = 1'b1;
                  shift_out.key   = key_ff;
                  shift_out.count = count_ff;
                  valid_in        = 1'b0;
               end else begin
                  tok_in_next.mode = TOK_DONE;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in_next;
      end
      key_ff   <= key_in;
      count_ff <= count_in;
   end

endmodule
